### src/bbtp_pkg.sv
`default_nettype none
package bbtp_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAG,
    ST_PRED
  } state_t;

  // Stored block kinds.
  localparam logic [1:0] KIND_INDIRECT = 2'd0;
  localparam logic [1:0] KIND_RETURN   = 2'd1;
  localparam logic [1:0] KIND_ALWAYS   = 2'd2;
  localparam logic [1:0] KIND_COND     = 2'd3;

  // Resolved branch kinds on an update.
  localparam logic [2:0] BK_NONE      = 3'd0;
  localparam logic [2:0] BK_JUMP      = 3'd1;
  localparam logic [2:0] BK_INDIRECT  = 3'd2;
  localparam logic [2:0] BK_COND      = 3'd3;
  localparam logic [2:0] BK_CALL      = 3'd4;
  localparam logic [2:0] BK_IND_CALL  = 3'd5;
  localparam logic [2:0] BK_RETURN    = 3'd6;
  localparam logic [2:0] BK_OTHER     = 3'd7;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam int HIST_W = 12;
  localparam int CL_W   = 4;
  localparam logic [CL_W-1:0] CALL_LENGTH_RESET     = 4'd4;
  localparam logic [CL_W-1:0] MAX_CALL_LENGTH_RESET = 4'd10;

  typedef struct packed {
    logic [63:0] tag;
    logic [63:0] branch;
    logic [63:0] next;
    logic [1:0]  kind;
  } entry_t;

endpackage
`default_nettype wire

### src/bbtp_block_table.sv
`default_nettype none
module bbtp_block_table #(
  parameter int SETS = 2048,
  parameter int WAYS = 4,
  parameter int SET_W = 11
) (
  input  wire logic               clk,
  input  wire logic               clr_en,
  input  wire logic [SET_W-1:0]   clr_set,
  input  wire logic               rd_en,
  input  wire logic [SET_W-1:0]   rd_set,
  input  wire logic [63:0]        tag,
  input  wire logic               act,
  input  wire logic               fill,
  input  wire bbtp_pkg::entry_t   fill_entry,
  output logic                    hit,
  output bbtp_pkg::entry_t        hit_entry
);
  import bbtp_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  entry_t [WAYS-1:0]           row_mem [SETS];
  logic [WAYS-1:0]             valid_mem [SETS];
  logic [WAYS-1:0][AGE_W-1:0]  age_mem [SETS];

  entry_t [WAYS-1:0]           row_q;
  logic [WAYS-1:0]             valid_q;
  logic [WAYS-1:0][AGE_W-1:0]  age_q;
  logic [SET_W-1:0]            set_r;

  logic [WAY_W-1:0]            hit_way;
  logic [WAY_W-1:0]            victim;
  logic [WAY_W-1:0]            way_sel;
  logic                        found_inv;
  logic                        found_old;
  logic [AGE_W:0]              old_age;
  logic [WAYS-1:0]             valid_nxt;
  logic [WAYS-1:0][AGE_W-1:0]  age_nxt;
  entry_t [WAYS-1:0]           row_nxt;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_q   <= row_mem[rd_set];
      valid_q <= valid_mem[rd_set];
      age_q   <= age_mem[rd_set];
      set_r   <= rd_set;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_en) begin
      valid_mem[clr_set] <= '0;
      age_mem[clr_set]   <= '0;
    end else if (act && (hit || fill)) begin
      valid_mem[set_r] <= valid_nxt;
      age_mem[set_r]   <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (act && fill) begin
      row_mem[set_r] <= row_nxt;
    end
  end

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    found_inv = 1'b0;
    found_old = 1'b0;
    victim    = '0;
    for (int v = 0; v < WAYS; v++) begin
      if (!hit && valid_q[v] && row_q[v].tag == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(v);
      end
    end
    for (int v = 0; v < WAYS; v++) begin
      if (!found_inv && !valid_q[v]) begin
        found_inv = 1'b1;
        victim    = WAY_W'(v);
      end
    end
    if (!found_inv) begin
      for (int v = 0; v < WAYS; v++) begin
        if (!found_old && age_q[v] == AGE_W'(WAYS - 1)) begin
          found_old = 1'b1;
          victim    = WAY_W'(v);
        end
      end
    end
    way_sel   = hit ? hit_way : victim;
    hit_entry = row_q[hit_way];

    // Ways younger than the touched one age by one; the touched way becomes newest.
    old_age = valid_q[way_sel] ? {1'b0, age_q[way_sel]} : (AGE_W + 1)'(WAYS);
    age_nxt = age_q;
    for (int v = 0; v < WAYS; v++) begin
      if (WAY_W'(v) != way_sel && valid_q[v] && {1'b0, age_q[v]} < old_age) begin
        age_nxt[v] = age_q[v] + AGE_W'(1);
      end
    end
    age_nxt[way_sel] = '0;
    valid_nxt = valid_q;
    if (fill) begin
      valid_nxt[way_sel] = 1'b1;
    end
    row_nxt = row_q;
    row_nxt[way_sel] = fill_entry;
  end

endmodule
`default_nettype wire

### src/bbtp_target_store.sv
`default_nettype none
module bbtp_target_store #(
  parameter int IND_ENTRIES = 4096,
  parameter int IND_W = 12,
  parameter int CL_ENTRIES = 1024,
  parameter int CLI_W = 10,
  parameter int STK_DEPTH = 64,
  parameter int PTR_W = 6
) (
  input  wire logic                       clk,
  input  wire logic                       stk_rd_en,
  input  wire logic [PTR_W-1:0]           stk_ra,
  output logic [63:0]                     stk_q,
  input  wire logic                       stk_we,
  input  wire logic [PTR_W-1:0]           stk_wa,
  input  wire logic [63:0]                stk_wd,
  input  wire logic                       ind_rd_en,
  input  wire logic [IND_W-1:0]           ind_ra,
  output logic [63:0]                     ind_q,
  input  wire logic                       ind_we,
  input  wire logic [IND_W-1:0]           ind_wa,
  input  wire logic [63:0]                ind_wd,
  input  wire logic                       cl_rd_en,
  input  wire logic [CLI_W-1:0]           cl_ra,
  output logic [bbtp_pkg::CL_W-1:0]       cl_q,
  input  wire logic                       cl_we,
  input  wire logic [CLI_W-1:0]           cl_wa,
  input  wire logic [bbtp_pkg::CL_W-1:0]  cl_wd
);
  import bbtp_pkg::*;

  logic [63:0]     stk_mem [STK_DEPTH];
  logic [63:0]     ind_mem [IND_ENTRIES];
  logic [CL_W-1:0] cl_mem  [CL_ENTRIES];

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_rd_en) begin
      stk_q <= stk_mem[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ind_we) begin
      ind_mem[ind_wa] <= ind_wd;
    end
    if (ind_rd_en) begin
      ind_q <= ind_mem[ind_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cl_we) begin
      cl_mem[cl_wa] <= cl_wd;
    end
    if (cl_rd_en) begin
      cl_q <= cl_mem[cl_ra];
    end
  end

endmodule
`default_nettype wire

### src/block_branch_target_predictor.sv
`default_nettype none
// Fetch-block branch target predictor with a return stack. After reset the block
// runs a clearing pass over the way state, the indirect table and the call length
// table, walking max(TABLE_SETS, INDIRECT_ENTRIES, CALL_LENGTH_ENTRIES) indices
// (4096 by default), and takes no word during it; configuration writes are taken
// in every state. Items are handled one at a time: an update registers its result
// word after the tag read and the update of the tables, a lookup after the tag
// read and a dependent read of the indirect and call length tables. A new word is
// taken only in the cycle after the previous result has been taken. TABLE_SETS,
// INDIRECT_ENTRIES and CALL_LENGTH_ENTRIES must be powers of two.
module block_branch_target_predictor #(
  parameter int TABLE_SETS = 2048,
  parameter int TABLE_WAYS = 4,
  parameter int INDIRECT_ENTRIES = 4096,
  parameter int STACK_DEPTH = 64,
  parameter int CALL_LENGTH_ENTRIES = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // block_addr[63:0], branch_addr[127:64], resolved_target[191:128],
  // was_taken[192], branch_kind[195:193], zero fill
  input  wire logic [199:0]  in_tdata,
  // op[0]
  input  wire logic [0:0]    in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // pred_branch_addr[63:0], pred_next_addr[127:64], pred_unconditional[128],
  // pred_found[129], update_hit[130], update_mispredict[131], zero fill
  output logic [135:0]       out_tdata,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [3:0]    cfg_data
);
  import bbtp_pkg::*;

  localparam int SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
  localparam int IND_W = $clog2(INDIRECT_ENTRIES);
  localparam int CLI_W = (CALL_LENGTH_ENTRIES > 1) ? $clog2(CALL_LENGTH_ENTRIES) : 1;
  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int CLR_MAX0 = (TABLE_SETS > INDIRECT_ENTRIES) ? TABLE_SETS : INDIRECT_ENTRIES;
  localparam int CLR_MAX = (CLR_MAX0 > CALL_LENGTH_ENTRIES) ? CLR_MAX0 : CALL_LENGTH_ENTRIES;
  localparam int CLR_W = $clog2(CLR_MAX);

  state_t            state_r, state_nxt;
  logic [CLR_W-1:0]  clr_r, clr_nxt;
  logic              op_r;
  logic [63:0]       blk_r, br_r, tgt_r;
  logic              taken_r;
  logic [2:0]        kind_r;
  logic [HIST_W-1:0] hist_r, hist_nxt;
  logic [PTR_W-1:0]  top_r, top_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [63:0]       kept_block_r, kept_branch_r, kept_target_r;
  logic [63:0]       kept_block_nxt, kept_branch_nxt, kept_target_nxt;
  logic [CL_W-1:0]   max_r;
  logic              out_valid_r, out_valid_nxt;
  logic [135:0]      out_data_r, out_data_nxt;
  logic              lk_hit_r;
  logic [1:0]        lk_kind_r;
  logic [63:0]       lk_branch_r, lk_next_r, lk_top_r;

  logic              accept;
  logic              tbl_hit, tbl_act, tbl_fill;
  entry_t            tbl_entry, fill_entry;
  logic              clr_tbl, clr_ind, clr_cl;
  logic [SET_W-1:0]  clr_set, rd_set;
  logic [63:0]       stk_q, ind_q, stk_wd, ind_wd;
  logic [CL_W-1:0]   cl_q, cl_wd;
  logic              stk_we, ind_we, ind_rd_en, cl_we, cl_rd_en;
  logic [PTR_W-1:0]  stk_wa;
  logic [IND_W-1:0]  ind_wa, ind_ra;
  logic [CLI_W-1:0]  cl_wa, cl_ra;
  logic [PTR_W-1:0]  top_inc, top_dec;
  logic              u_hit, u_req, u_mis;
  logic [63:0]       call_dist, next_blk, pb, pt;
  logic [1:0]        u_type;

  assign in_tready  = (state_r == ST_IDLE) && !out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  assign rd_set  = SET_W'(in_tdata[63:0]) & SET_W'(TABLE_SETS - 1);
  assign clr_set = SET_W'(clr_r) & SET_W'(TABLE_SETS - 1);
  assign top_inc = (top_r == PTR_W'(STACK_DEPTH - 1)) ? '0 : top_r + PTR_W'(1);
  assign top_dec = (top_r == '0) ? PTR_W'(STACK_DEPTH - 1) : top_r - PTR_W'(1);

  bbtp_block_table #(
    .SETS (TABLE_SETS),
    .WAYS (TABLE_WAYS),
    .SET_W(SET_W)
  ) u_table (
    .clk       (clk),
    .clr_en    (clr_tbl),
    .clr_set   (clr_set),
    .rd_en     (accept),
    .rd_set    (rd_set),
    .tag       (blk_r),
    .act       (tbl_act),
    .fill      (tbl_fill),
    .fill_entry(fill_entry),
    .hit       (tbl_hit),
    .hit_entry (tbl_entry)
  );

  bbtp_target_store #(
    .IND_ENTRIES(INDIRECT_ENTRIES),
    .IND_W      (IND_W),
    .CL_ENTRIES (CALL_LENGTH_ENTRIES),
    .CLI_W      (CLI_W),
    .STK_DEPTH  (STACK_DEPTH),
    .PTR_W      (PTR_W)
  ) u_store (
    .clk      (clk),
    .stk_rd_en(accept),
    .stk_ra   (top_r),
    .stk_q    (stk_q),
    .stk_we   (stk_we),
    .stk_wa   (stk_wa),
    .stk_wd   (stk_wd),
    .ind_rd_en(ind_rd_en),
    .ind_ra   (ind_ra),
    .ind_q    (ind_q),
    .ind_we   (ind_we),
    .ind_wa   (ind_wa),
    .ind_wd   (ind_wd),
    .cl_rd_en (cl_rd_en),
    .cl_ra    (cl_ra),
    .cl_q     (cl_q),
    .cl_we    (cl_we),
    .cl_wa    (cl_wa),
    .cl_wd    (cl_wd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      hist_r        <= '0;
      top_r         <= '0;
      cnt_r         <= '0;
      kept_block_r  <= '0;
      kept_branch_r <= '0;
      kept_target_r <= '0;
      max_r         <= MAX_CALL_LENGTH_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      hist_r        <= hist_nxt;
      top_r         <= top_nxt;
      cnt_r         <= cnt_nxt;
      kept_block_r  <= kept_block_nxt;
      kept_branch_r <= kept_branch_nxt;
      kept_target_r <= kept_target_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      op_r    <= in_tuser[0];
      blk_r   <= in_tdata[63:0];
      br_r    <= in_tdata[127:64];
      tgt_r   <= in_tdata[191:128];
      taken_r <= in_tdata[192];
      kind_r  <= in_tdata[195:193];
    end
    if (state_r == ST_TAG) begin
      lk_hit_r    <= tbl_hit;
      lk_kind_r   <= tbl_entry.kind;
      lk_branch_r <= tbl_entry.branch;
      lk_next_r   <= tbl_entry.next;
      lk_top_r    <= stk_q;
    end
  end

  always_comb begin
    call_dist       = (stk_q > tgt_r) ? stk_q - tgt_r : tgt_r - stk_q;
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    hist_nxt        = hist_r;
    top_nxt         = top_r;
    cnt_nxt         = cnt_r;
    kept_block_nxt  = kept_block_r;
    kept_branch_nxt = kept_branch_r;
    kept_target_nxt = kept_target_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    tbl_act   = 1'b0;
    tbl_fill  = 1'b0;
    clr_tbl   = 1'b0;
    clr_ind   = 1'b0;
    clr_cl    = 1'b0;
    stk_we    = 1'b0;
    stk_wa    = top_inc;
    stk_wd    = br_r;
    ind_we    = 1'b0;
    ind_wa    = IND_W'(br_r ^ 64'(hist_r));
    ind_wd    = tgt_r;
    ind_rd_en = 1'b0;
    ind_ra    = IND_W'(tbl_entry.branch ^ 64'(hist_r));
    cl_we     = 1'b0;
    cl_wa     = CLI_W'(stk_q) & CLI_W'(CALL_LENGTH_ENTRIES - 1);
    cl_wd     = CL_W'(call_dist);
    cl_rd_en  = 1'b0;
    cl_ra     = CLI_W'(stk_q) & CLI_W'(CALL_LENGTH_ENTRIES - 1);

    u_hit    = (kept_block_r == blk_r) &&
               ((kind_r == BK_NONE) ? (kept_branch_r == '0) : (kept_branch_r == br_r));
    u_req    = (kind_r != BK_NONE) &&
               (taken_r || (kind_r != BK_COND && kind_r != BK_OTHER));
    u_mis    = u_req && !(u_hit && kept_target_r == tgt_r);
    case (kind_r)
      BK_INDIRECT, BK_IND_CALL: u_type = KIND_INDIRECT;
      BK_RETURN:                u_type = KIND_RETURN;
      BK_COND, BK_OTHER:        u_type = KIND_COND;
      default:                  u_type = KIND_ALWAYS;
    endcase
    next_blk = (kind_r != BK_NONE && (taken_r || u_type != KIND_COND)) ? tgt_r : '0;
    fill_entry.tag    = blk_r;
    fill_entry.branch = br_r;
    fill_entry.next   = next_blk;
    fill_entry.kind   = u_type;

    case (lk_kind_r)
      KIND_RETURN:   pt = (cnt_r != '0) ? lk_top_r + 64'(cl_q) : '0;
      KIND_INDIRECT: pt = ind_q;
      default:       pt = lk_next_r;
    endcase
    if (!lk_hit_r) begin
      pt = '0;
    end
    pb = lk_hit_r ? lk_branch_r : '0;

    case (state_r)
      ST_CLEAR: begin
        clr_tbl = {1'b0, clr_r} < (CLR_W + 1)'(TABLE_SETS);
        clr_ind = {1'b0, clr_r} < (CLR_W + 1)'(INDIRECT_ENTRIES);
        clr_cl  = {1'b0, clr_r} < (CLR_W + 1)'(CALL_LENGTH_ENTRIES);
        ind_we  = clr_ind;
        ind_wa  = IND_W'(clr_r);
        ind_wd  = '0;
        cl_we   = clr_cl;
        cl_wa   = CLI_W'(clr_r);
        cl_wd   = CALL_LENGTH_RESET;
        clr_nxt = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(CLR_MAX - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_TAG;
        end
      end
      ST_TAG: begin
        tbl_act = 1'b1;
        if (op_r == OP_LOOKUP) begin
          ind_rd_en = 1'b1;
          cl_rd_en  = 1'b1;
          state_nxt = ST_PRED;
        end else begin
          tbl_fill = next_blk != '0;
          if (kind_r == BK_CALL || kind_r == BK_IND_CALL) begin
            stk_we  = 1'b1;
            top_nxt = top_inc;
            if (cnt_r != CNT_W'(STACK_DEPTH)) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          ind_we = (kind_r == BK_INDIRECT || kind_r == BK_IND_CALL);
          if (kind_r == BK_COND || kind_r == BK_OTHER) begin
            hist_nxt = {hist_r[HIST_W-2:0], taken_r};
          end
          if (kind_r == BK_RETURN && cnt_r != '0) begin
            top_nxt = top_dec;
            cnt_nxt = cnt_r - CNT_W'(1);
            cl_we   = call_dist <= 64'(max_r);
          end
          out_data_nxt  = {4'b0, u_mis, u_hit, 130'b0};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_PRED: begin
        kept_block_nxt  = blk_r;
        kept_branch_nxt = pb;
        kept_target_nxt = pt;
        out_data_nxt  = {4'b0, 2'b00, lk_hit_r, lk_hit_r && lk_kind_r != KIND_COND, pt, pb};
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("return stack count above depth");

  a_accept_to_tag: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_TAG)
    else $error("accepted word did not start a table read");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_tready)
    else $error("input taken during clearing pass");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_valid_r)
    else $error("input taken while a result is pending");

endmodule
`default_nettype wire
